// ===== rtl/dws_pkg.sv =====
package dws_pkg;

    localparam int CHAR_W         = 8;
    localparam int OUT_W          = 32;
    localparam int CFG_CHARS_W    = 64;
    localparam int CFG_COUNT_W    = 4;
    localparam int DEF_MAX_DELIMS = 8;
    localparam int DEF_POS_WIDTH  = 32;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 64;
    localparam int REG_IDX_W      = 2;

    // Register indexes; register i sits at byte address 8*i.
    localparam logic [REG_IDX_W-1:0] REG_DELIM_CHARS = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_OFFSET = 2'd2;

    localparam logic [CFG_COUNT_W-1:0] DELIM_COUNT_RESET = 4'd1;

    typedef struct packed {
        logic [CFG_CHARS_W-1:0] delim_chars;
        logic [CFG_COUNT_W-1:0] delim_count;
        logic [OUT_W-1:0]       base_offset;
    } dws_cfg_t;

    typedef struct packed {
        logic advance;
        logic hit;
        logic last;
    } dws_step_t;

endpackage

// ===== rtl/dws_if.sv =====
interface dws_char_if;
    import dws_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, char_code, last_char, input ready);
    modport sink (input valid, char_code, last_char, output ready);
endinterface

interface dws_word_if;
    import dws_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] word_start;
    logic [OUT_W-1:0] word_length;
    logic             last_word;

    modport source (output valid, word_start, word_length, last_word, input ready);
    modport sink (input valid, word_start, word_length, last_word, output ready);
endinterface

// ===== rtl/dws_cfg_regs.sv =====
module dws_cfg_regs (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [dws_pkg::PADDR_W-1:0] paddr,
    input  logic [dws_pkg::PDATA_W-1:0] pwdata,
    output logic [dws_pkg::PDATA_W-1:0] prdata,
    output logic                     pready,
    output dws_pkg::dws_cfg_t        cfg
);
    import dws_pkg::*;

    dws_cfg_t             cfg_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.delim_chars <= '0;
            cfg_reg.delim_count <= DELIM_COUNT_RESET;
            cfg_reg.base_offset <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DELIM_CHARS: cfg_reg.delim_chars <= pwdata[CFG_CHARS_W-1:0];
                REG_DELIM_COUNT: cfg_reg.delim_count <= pwdata[CFG_COUNT_W-1:0];
                REG_BASE_OFFSET: cfg_reg.base_offset <= pwdata[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DELIM_CHARS: prdata = PDATA_W'(cfg_reg.delim_chars);
            REG_DELIM_COUNT: prdata = PDATA_W'(cfg_reg.delim_count);
            REG_BASE_OFFSET: prdata = PDATA_W'(cfg_reg.base_offset);
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/dws_delim_match.sv =====
module dws_delim_match #(
    parameter int MAX_DELIMS = dws_pkg::DEF_MAX_DELIMS
) (
    input  dws_pkg::dws_cfg_t           cfg,
    input  logic [dws_pkg::CHAR_W-1:0]  char_code,
    output logic                        hit
);
    import dws_pkg::*;

    logic [CFG_COUNT_W-1:0] eff_count;
    logic [MAX_DELIMS-1:0]  lane_hit;

    // Counts above the lane count enable every lane.
    assign eff_count = (cfg.delim_count > CFG_COUNT_W'(MAX_DELIMS)) ?
                       CFG_COUNT_W'(MAX_DELIMS) : cfg.delim_count;

    always_comb
    begin
        for (int i = 0; i < MAX_DELIMS; i++)
        begin
            lane_hit[i] = (CFG_COUNT_W'(i) < eff_count) &&
                          (cfg.delim_chars[CHAR_W*i +: CHAR_W] == char_code);
        end
    end

    assign hit = |lane_hit;

endmodule

// ===== rtl/dws_word_track.sv =====
module dws_word_track #(
    parameter int POS_WIDTH = dws_pkg::DEF_POS_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  dws_pkg::dws_cfg_t          cfg,
    input  dws_pkg::dws_step_t         step,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [dws_pkg::OUT_W-1:0]  word_start,
    output logic [dws_pkg::OUT_W-1:0]  word_length,
    output logic                       last_word
);
    import dws_pkg::*;

    localparam int SUM_W = ((POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W) + 1;
    localparam logic [SUM_W-1:0] OUT_MAX = SUM_W'({OUT_W{1'b1}});

    logic [POS_WIDTH-1:0] pos_reg;
    logic [POS_WIDTH-1:0] pos_next;
    logic [POS_WIDTH-1:0] start_reg;
    logic [POS_WIDTH-1:0] start_next;
    logic [POS_WIDTH-1:0] pos_inc;
    logic [POS_WIDTH-1:0] word_end;
    logic [SUM_W-1:0]     start_sum;
    logic [SUM_W-1:0]     len_wide;
    logic                 emit;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     word_start_reg;
    logic [OUT_W-1:0]     word_length_reg;
    logic                 last_word_reg;
    logic [OUT_W-1:0]     word_start_next;
    logic [OUT_W-1:0]     word_length_next;

    // Positions stick at all ones instead of wrapping.
    assign pos_inc = (pos_reg == {POS_WIDTH{1'b1}}) ? pos_reg : pos_reg + POS_WIDTH'(1);

    assign emit = (cfg.delim_count != '0) && (step.hit || step.last);

    // A delimiter ends the word before itself; a final non-delimiter includes itself.
    assign word_end  = step.hit ? pos_reg : pos_inc;
    assign start_sum = SUM_W'(start_reg) + SUM_W'(cfg.base_offset);
    assign len_wide  = SUM_W'(word_end) - SUM_W'(start_reg);

    always_comb
    begin
        word_start_next = (start_sum > OUT_MAX) ? {OUT_W{1'b1}} : start_sum[OUT_W-1:0];
        if (word_end < start_reg)
        begin
            word_length_next = '0;
        end
        else if (len_wide > OUT_MAX)
        begin
            word_length_next = {OUT_W{1'b1}};
        end
        else
        begin
            word_length_next = len_wide[OUT_W-1:0];
        end

        pos_next   = pos_reg;
        start_next = start_reg;
        if (step.advance)
        begin
            if (step.last)
            begin
                pos_next   = '0;
                start_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
                if (emit)
                begin
                    start_next = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            start_reg <= start_next;
            if (step.advance)
            begin
                out_valid_reg <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.advance && emit)
        begin
            word_start_reg  <= word_start_next;
            word_length_reg <= word_length_next;
            last_word_reg   <= step.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_start  = word_start_reg;
    assign word_length = word_length_reg;
    assign last_word   = last_word_reg;

    // The open word never starts past the current position.
    a_start_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg <= pos_reg)
        else $error("word start ahead of position");

    // Finishing a document returns both positions to zero.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step.advance && step.last |=> (pos_reg == '0) && (start_reg == '0))
        else $error("position not cleared after final character");

    // An item that yields no word leaves the result register empty.
    a_no_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
        step.advance && !emit |=> !out_valid_reg)
        else $error("result shown for an item without a word");

    // A result may only be replaced when it has been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !step.advance)
        else $error("pending result overwritten");

endmodule

// ===== rtl/delimiter_word_splitter.sv =====
// Channel   Role   Payload                                   Accepted when
// --------  -----  ----------------------------------------  -------------------
// in_ch     sink   char_code[7:0], last_char                  valid && ready
// out_ch    source word_start[31:0], word_length[31:0],       valid && ready
//                  last_word
// APB       slave  delim_chars @0x00, delim_count @0x08,      psel && penable &&
//                  base_offset @0x10                          pwrite
//
// Each item passes from acceptance through the input register and then the result
// register. The block accepts one item every cycle while out_ch is not stalled;
// the state update (position, word start) is a single increment and the
// word figures are one add and one subtract, all between those two registers.
// Reset (rst_n, asynchronous, active low) clears the positions, the pipeline
// valid bits and the registers to their defaults (delim_count = 1).
// When out_ch stalls with a word pending, the input register holds and in_ch
// ready drops; items that produce no word still need the result slot free or
// draining, so the stall reaches the input for them too.
module delimiter_word_splitter #(
    parameter int MAX_DELIMS = dws_pkg::DEF_MAX_DELIMS,
    parameter int POS_WIDTH  = dws_pkg::DEF_POS_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dws_pkg::PADDR_W-1:0] paddr,
    input  logic [dws_pkg::PDATA_W-1:0] pwdata,
    output logic [dws_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    dws_char_if.sink                    in_ch,
    dws_word_if.source                  out_ch
);
    import dws_pkg::*;

    dws_cfg_t          cfg;
    dws_step_t         step;
    logic              in_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              last_reg;
    logic              hit;
    logic              advance;
    logic              in_take;

    // Configuration registers must be written by the user only while the pipeline
    // is empty, so in-flight items always see a stable set; the block does not enforce it.
    dws_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The registered item moves on when the result slot is empty or is being
    // drained this cycle, whether or not the item produces a word.
    assign advance     = in_valid_reg && (!out_ch.valid || out_ch.ready);
    assign in_take     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= in_ch.char_code;
            last_reg <= in_ch.last_char;
        end
    end

    dws_delim_match #(
        .MAX_DELIMS (MAX_DELIMS)
    ) u_match (
        .cfg       (cfg),
        .char_code (char_reg),
        .hit       (hit)
    );

    assign step.advance = advance;
    assign step.hit     = hit;
    assign step.last    = last_reg;

    dws_word_track #(
        .POS_WIDTH (POS_WIDTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step        (step),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .word_start  (out_ch.word_start),
        .word_length (out_ch.word_length),
        .last_word   (out_ch.last_word)
    );

    // A held item stays in the input register until it can move on.
    a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(char_reg) && $stable(last_reg))
        else $error("held item lost or changed");

endmodule
